// ===== hw/rtl/cht_pkg.sv =====
package cht_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned KEY_BITS        = 16;
  localparam int unsigned VALUE_BITS      = 64;
  localparam int unsigned CMD_BITS        = 2;
  localparam int unsigned STATUS_BITS     = 2;
  localparam int unsigned BUCKET_OUT_BITS = 3;

  // Default geometry of the table
  localparam int unsigned NUM_BUCKETS_DEFAULT = 8;
  localparam int unsigned CHAIN_DEPTH_DEFAULT = 8;

  // Command codes; the unused code behaves as a find
  typedef enum logic [CMD_BITS-1:0] {
    CMD_FIND   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_BAD_KEY   = 2'd3
  } status_e;

  typedef struct packed {
    logic [CMD_BITS-1:0]   cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [BUCKET_OUT_BITS-1:0] bucket;
    logic [VALUE_BITS-1:0]      found_value;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_WALK,
    S_SHIFT,
    S_DONE
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    hash_step;
    logic    rd_issue;
    logic    wr_en;
    logic    wr_shift;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    res_load;
    status_e res_status;
    logic    res_from_mem;
    logic    out_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_key_zero;
    logic hash_done;
    logic is_insert;
    logic is_delete;
    logic chain_full;
    logic chain_empty;
    logic key_match;
    logic rd_at_end;
  } dp_status_t;

endpackage

// ===== hw/rtl/cht_dpath.sv =====
module cht_dpath import cht_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEFAULT,
  parameter int unsigned CHAIN_DEPTH = CHAIN_DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_data_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_data_o
);

  localparam int unsigned NUM_SLOTS = NUM_BUCKETS * CHAIN_DEPTH;
  localparam int unsigned BKT_W     = $clog2(NUM_BUCKETS);
  localparam int unsigned CNT_W     = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned ADDR_W    = $clog2(NUM_SLOTS);
  localparam bit          NB_POW2   = (NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0;

  localparam logic [CNT_W-1:0]  CD_CNT  = CNT_W'(CHAIN_DEPTH);
  localparam logic [ADDR_W-1:0] CD_ADDR = ADDR_W'(CHAIN_DEPTH);

  in_item_t         item_q;
  logic [BKT_W-1:0] bucket;
  logic             hash_done;
  logic             is_insert;
  logic             is_delete;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= in_data_i;
    end
  end

  always_comb begin
    is_insert = 1'b0;
    is_delete = 1'b0;
    case (cmd_e'(item_q.cmd))
      CMD_INSERT: begin
        is_insert = 1'b1;
      end
      CMD_DELETE: begin
        is_delete = 1'b1;
      end
      CMD_FIND: begin
      end
      default: begin
      end
    endcase
  end

  // Bucket index: (key - 1) mod NUM_BUCKETS
  if (NB_POW2) begin : g_hash_mask
    logic [KEY_BITS-1:0] dvd_q;

    always_ff @(posedge clk_i) begin
      if (cmd_i.load_item) begin
        dvd_q <= in_data_i.key - KEY_BITS'(1);
      end
    end

    assign bucket    = dvd_q[BKT_W-1:0];
    assign hash_done = 1'b1;
  end else begin : g_hash_recip
    // Quotient by reciprocal multiplication, exact for every KEY_BITS-wide dividend
    localparam int unsigned       SHIFT    = KEY_BITS + BKT_W;
    localparam int unsigned       RCP_W    = KEY_BITS + 2;
    localparam int unsigned       PROD_W   = KEY_BITS + RCP_W;
    localparam int unsigned       QUO_W    = KEY_BITS - BKT_W + 1;
    localparam longint unsigned   RCP_FULL = ((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1)
                                             / 64'(NUM_BUCKETS);
    localparam logic [RCP_W-1:0]    RCP_M  = RCP_W'(RCP_FULL);
    localparam logic [KEY_BITS-1:0] NB_K   = KEY_BITS'(NUM_BUCKETS);
    localparam logic [1:0]          HC_END = 2'd2;

    logic [KEY_BITS-1:0] dvd_q;
    logic [PROD_W-1:0]   prod_q;
    logic [BKT_W-1:0]    rem_q;
    logic [1:0]          hcnt_q;
    logic [QUO_W-1:0]    quot;
    logic [KEY_BITS-1:0] quot_nb;
    logic [KEY_BITS-1:0] rem_full;

    assign quot     = prod_q[SHIFT +: QUO_W];
    assign quot_nb  = KEY_BITS'(quot) * NB_K;
    assign rem_full = dvd_q - quot_nb;

    // First step forms the product, the second the remainder
    always_ff @(posedge clk_i) begin
      if (cmd_i.load_item) begin
        dvd_q <= in_data_i.key - KEY_BITS'(1);
      end else if (cmd_i.hash_step) begin
        prod_q <= PROD_W'(dvd_q) * PROD_W'(RCP_M);
        rem_q  <= rem_full[BKT_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        hcnt_q <= '0;
      end else if (cmd_i.load_item) begin
        hcnt_q <= '0;
      end else if (cmd_i.hash_step) begin
        hcnt_q <= hcnt_q + 2'd1;
      end
    end

    assign bucket    = rem_q;
    assign hash_done = (hcnt_q == HC_END);
  end

  // Chain fill counts, one per bucket
  logic [CNT_W-1:0] cnt_q [NUM_BUCKETS];
  logic [CNT_W-1:0] cnt_rd;

  assign cnt_rd = cnt_q[bucket];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        cnt_q[b] <= '0;
      end
    end else if (cmd_i.cnt_inc) begin
      cnt_q[bucket] <= cnt_rd + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_q[bucket] <= cnt_rd - CNT_W'(1);
    end
  end

  // Next chain position to read
  logic [CNT_W-1:0] ridx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ridx_q <= '0;
    end else if (cmd_i.load_item) begin
      ridx_q <= '0;
    end else if (cmd_i.rd_issue) begin
      ridx_q <= ridx_q + CNT_W'(1);
    end
  end

  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] wr_addr;
  entry_t            wr_entry;
  entry_t            rdata_q;
  entry_t            mem_q [NUM_SLOTS];

  assign base    = ADDR_W'(bucket) * CD_ADDR;
  assign rd_addr = base + ADDR_W'(ridx_q);
  // A shift writes two places behind the read pointer
  assign wr_addr = cmd_i.wr_shift ? (rd_addr - ADDR_W'(2)) : (base + ADDR_W'(cnt_rd));

  always_comb begin
    if (cmd_i.wr_shift) begin
      wr_entry = rdata_q;
    end else begin
      wr_entry.key   = item_q.key;
      wr_entry.value = item_q.value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[wr_addr] <= wr_entry;
    end
    if (cmd_i.rd_issue) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Result and output registers
  logic [BKT_W+BUCKET_OUT_BITS-1:0] bkt_ext;
  out_item_t                        res_q;
  out_item_t                        out_q;

  assign bkt_ext = (BKT_W + BUCKET_OUT_BITS)'(bucket);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q.status      <= cmd_i.res_status;
      res_q.bucket      <= (cmd_i.res_status == ST_BAD_KEY) ? '0
                                                            : bkt_ext[BUCKET_OUT_BITS-1:0];
      res_q.found_value <= cmd_i.res_from_mem ? rdata_q.value : '0;
    end
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
  end

  assign out_data_o = out_q;

  assign status_o.in_key_zero = (in_data_i.key == '0);
  assign status_o.hash_done   = hash_done;
  assign status_o.is_insert   = is_insert;
  assign status_o.is_delete   = is_delete;
  assign status_o.chain_full  = (cnt_rd == CD_CNT);
  assign status_o.chain_empty = (cnt_rd == '0);
  assign status_o.key_match   = (rdata_q.key == item_q.key);
  assign status_o.rd_at_end   = (ridx_q == cnt_rd);

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
module cht_ctrl import cht_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e state_q;
  ctrl_state_e state_d;
  logic        out_valid_q;
  logic        out_valid_d;
  logic        out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.res_status = ST_OK;
    in_stall_o       = (state_q != S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (status_i.in_key_zero) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_BAD_KEY;
            state_d          = S_DONE;
          end else begin
            state_d = S_HASH;
          end
        end
      end

      S_HASH: begin
        if (!status_i.hash_done) begin
          cmd_o.hash_step = 1'b1;
        end else if (status_i.is_insert) begin
          cmd_o.res_load = 1'b1;
          if (status_i.chain_full) begin
            cmd_o.res_status = ST_FULL;
          end else begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.cnt_inc = 1'b1;
          end
          state_d = S_DONE;
        end else if (status_i.chain_empty) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
          state_d        = S_WALK;
        end
      end

      // Compare the entry read last cycle, fetch the next one meanwhile
      S_WALK: begin
        if (status_i.key_match) begin
          if (!status_i.is_delete) begin
            cmd_o.res_load     = 1'b1;
            cmd_o.res_from_mem = 1'b1;
            state_d            = S_DONE;
          end else if (status_i.rd_at_end) begin
            cmd_o.cnt_dec  = 1'b1;
            cmd_o.res_load = 1'b1;
            state_d        = S_DONE;
          end else begin
            cmd_o.rd_issue = 1'b1;
            state_d        = S_SHIFT;
          end
        end else if (status_i.rd_at_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOT_FOUND;
          state_d          = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end

      // Move each later entry down one place
      S_SHIFT: begin
        cmd_o.wr_en    = 1'b1;
        cmd_o.wr_shift = 1'b1;
        if (status_i.rd_at_end) begin
          cmd_o.cnt_dec  = 1'b1;
          cmd_o.res_load = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end

      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
// Keyed store with separate chaining: each input transfer is a find, insert or delete on a
// key, and each gives exactly one result transfer (status, bucket, found value). Key k lives
// in bucket (k-1) mod NUM_BUCKETS, whose chain holds up to CHAIN_DEPTH entries in insertion
// order; insert appends (duplicates allowed), find returns the oldest match, delete removes
// it and closes the gap. Key zero is refused with status 3. One item is handled at a time.
// The chain walk and the delete shift step through the single-port entry memory, one entry
// a cycle. When NUM_BUCKETS is not a power of two the bucket is worked out by a reciprocal
// multiplication and a multiply-subtract, registered over two steps, for every item with a
// nonzero key. The next item is taken while a result still waits in the output register.
module chained_hash_table import cht_pkg::*; #(
  parameter int unsigned NUM_BUCKETS = NUM_BUCKETS_DEFAULT,
  parameter int unsigned CHAIN_DEPTH = CHAIN_DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,

  // Command channel
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,

  // Result channel
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  // Sequence each command: hash, walk the chain, shift on delete, then post the result
  cht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // Hold the item, the bucket hash, chain counts, entry memory and the result registers
  cht_dpath #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (dp_cmd),
    .status_o   (dp_status),
    .out_data_o (out_data_o)
  );

endmodule
